FILE: sv/fca_pkg.sv
// Package: shared types, codes and constants of the FAT cluster address unit.
package fca_pkg;

  localparam int unsigned RootW = 22;

  // Table formats
  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  // Actions
  localparam logic [1:0] ACT_LOCATE = 2'd0;
  localparam logic [1:0] ACT_DECODE = 2'd1;
  localparam logic [1:0] ACT_DATA   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_FAT_KIND       = 3'd0;
  localparam logic [2:0] CFG_PARTITION_BASE = 3'd1;
  localparam logic [2:0] CFG_SECTOR_SHIFT   = 3'd2;
  localparam logic [2:0] CFG_CLUSTER_SECS   = 3'd3;
  localparam logic [2:0] CFG_RESERVED_COUNT = 3'd4;
  localparam logic [2:0] CFG_TABLE_COPIES   = 3'd5;
  localparam logic [2:0] CFG_TABLE_SECTORS  = 3'd6;
  localparam logic [2:0] CFG_ROOT_ENTRIES   = 3'd7;

  // Decode masks and end-of-chain marks
  localparam logic [11:0] FAT12_MASK = 12'hFFF;
  localparam logic [31:0] FAT12_EOC  = 32'h0000_0FF8;
  localparam logic [31:0] FAT16_EOC  = 32'h0000_FFF8;
  localparam logic [31:0] FAT32_MASK = 32'h0FFF_FFFF;
  localparam logic [31:0] FAT32_EOC  = 32'h0FFF_FFF8;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] cluster;
    logic [31:0] raw_entry;
  } in_item_t;

  typedef struct packed {
    logic [31:0] byte_address;
    logic [31:0] next_cluster;
    logic        chain_continues;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  fat_kind;
    logic [31:0] partition_base;
    logic [3:0]  sector_size_shift;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [7:0]  table_copies;
    logic [31:0] table_sectors;
    logic [15:0] root_entries;
  } cfg_t;

  // After stage 1: products, offsets and the finished decode
  typedef struct packed {
    logic [1:0]       action;
    logic [31:0]      entry_off;
    logic [31:0]      res_base;
    logic [31:0]      clus_prod;
    logic [31:0]      table_prod;
    logic [RootW-1:0] root_secs;
    logic [31:0]      next_cluster;
    logic             chain_continues;
  } s1_t;

  // After stage 2: pairwise sums
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] loc_part;
    logic [31:0] entry_off;
    logic [31:0] sec_a;
    logic [31:0] sec_b;
    logic [31:0] next_cluster;
    logic        chain_continues;
  } s2_t;

  // After stage 3: table entry address and data sector
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] loc_addr;
    logic [31:0] sector;
    logic [31:0] next_cluster;
    logic        chain_continues;
  } s3_t;

endpackage

FILE: sv/fca_prep.sv
// Stage 1: entry offset, region products, root directory size and entry decode.
module fca_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  fca_pkg::cfg_t    cfg,
  input  logic             up_valid,
  output logic             up_ready,
  input  fca_pkg::in_item_t up_item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output fca_pkg::s1_t     dn_item
);
  import fca_pkg::*;

  logic             valid_r;
  s1_t              item_r;
  s1_t              item_nxt;
  logic [31:0]      clus_rel;
  logic [RootW-1:0] bps_m1;
  logic [RootW-1:0] root_bytes;
  logic [15:0]      v16;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  assign clus_rel   = up_item.cluster - FIRST_DATA_CLUSTER;
  assign bps_m1     = (RootW'(1) << cfg.sector_size_shift) - RootW'(1);
  assign root_bytes = {1'b0, cfg.root_entries, 5'b0_0000} + bps_m1;
  assign v16        = up_item.raw_entry[15:0];

  always_comb begin
    item_nxt            = '0;
    item_nxt.action     = up_item.action;
    item_nxt.res_base   = 32'({16'b0, cfg.reserved_count} << cfg.sector_size_shift);
    item_nxt.clus_prod  = 32'(clus_rel * {24'b0, cfg.cluster_sectors});
    item_nxt.table_prod = 32'(cfg.table_sectors * {24'b0, cfg.table_copies});
    item_nxt.root_secs  = root_bytes >> cfg.sector_size_shift;

    case (cfg.fat_kind)
      KIND_FAT12: item_nxt.entry_off = up_item.cluster + (up_item.cluster >> 1);
      KIND_FAT16: item_nxt.entry_off = up_item.cluster << 1;
      KIND_FAT32: item_nxt.entry_off = up_item.cluster << 2;
      default:    item_nxt.entry_off = '0;
    endcase

    // Decode finishes here; other actions leave next/continue at zero
    if (up_item.action == ACT_DECODE) begin
      case (cfg.fat_kind)
        KIND_FAT12: begin
          item_nxt.next_cluster = up_item.cluster[0] ? {20'b0, v16[15:4]}
                                                     : {20'b0, v16[11:0] & FAT12_MASK};
          item_nxt.chain_continues = item_nxt.next_cluster < FAT12_EOC;
        end
        KIND_FAT16: begin
          item_nxt.next_cluster    = {16'b0, v16};
          item_nxt.chain_continues = item_nxt.next_cluster < FAT16_EOC;
        end
        KIND_FAT32: begin
          item_nxt.next_cluster    = up_item.raw_entry & FAT32_MASK;
          item_nxt.chain_continues = item_nxt.next_cluster < FAT32_EOC;
        end
        default: begin
          item_nxt.next_cluster    = '0;
          item_nxt.chain_continues = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: sv/fca_accum.sv
// Stage 2: pairwise sums of the table entry and data sector terms.
module fca_accum (
  input  logic          clk,
  input  logic          rst_n,
  input  fca_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  fca_pkg::s1_t  up_item,
  output logic          dn_valid,
  input  logic          dn_ready,
  output fca_pkg::s2_t  dn_item
);
  import fca_pkg::*;

  logic valid_r;
  s2_t  item_r;
  s2_t  item_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_comb begin
    item_nxt.action          = up_item.action;
    item_nxt.loc_part        = cfg.partition_base + up_item.res_base;
    item_nxt.entry_off       = up_item.entry_off;
    item_nxt.sec_a           = up_item.clus_prod + up_item.table_prod;
    item_nxt.sec_b           = {16'b0, cfg.reserved_count}
                             + {{(32 - RootW){1'b0}}, up_item.root_secs};
    item_nxt.next_cluster    = up_item.next_cluster;
    item_nxt.chain_continues = up_item.chain_continues;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: sv/fca_merge.sv
// Stage 3: final table entry address and absolute data sector.
module fca_merge (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  fca_pkg::s2_t up_item,
  output logic         dn_valid,
  input  logic         dn_ready,
  output fca_pkg::s3_t dn_item
);
  import fca_pkg::*;

  logic valid_r;
  s3_t  item_r;
  s3_t  item_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_comb begin
    item_nxt.action          = up_item.action;
    item_nxt.loc_addr        = up_item.loc_part + up_item.entry_off;
    item_nxt.sector          = up_item.sec_a + up_item.sec_b;
    item_nxt.next_cluster    = up_item.next_cluster;
    item_nxt.chain_continues = up_item.chain_continues;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: sv/fca_final.sv
// Stage 4: data sector to byte address, result select and output register.
module fca_final (
  input  logic               clk,
  input  logic               rst_n,
  input  fca_pkg::cfg_t      cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  fca_pkg::s3_t       up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output fca_pkg::out_item_t dn_item
);
  import fca_pkg::*;

  logic      valid_r;
  out_item_t item_r;
  out_item_t item_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_comb begin
    item_nxt.next_cluster    = up_item.next_cluster;
    item_nxt.chain_continues = up_item.chain_continues;
    case (up_item.action)
      ACT_LOCATE: item_nxt.byte_address = up_item.loc_addr;
      ACT_DATA:   item_nxt.byte_address = cfg.partition_base
                                          + (up_item.sector << cfg.sector_size_shift);
      default:    item_nxt.byte_address = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: sv/fat_cluster_address_unit.sv
// Top level: configuration registers and the four-stage address pipeline.
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+-----------------------------------
//  input    | in_valid, in_ready, in_data    | action, cluster, raw_entry
//  result   | out_valid, out_ready, out_data | byte_address, next_cluster, cont.
//  config   | cfg_we, cfg_index, cfg_wdata   | register index 0..7, 32-bit data
//
//  Every item's result passes through the four register stages (products,
//  pairwise sums, final sums, shift and select) in order; one item enters per
//  cycle while in_ready is high.
//  Synchronous active-low reset clears the stage valid bits and loads the
//  register defaults. A stall on out_ready holds each full stage; empty
//  stages still fill, so in_ready drops only when all four stages are full.
module fat_cluster_address_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fca_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fca_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import fca_pkg::*;

  cfg_t cfg_r;

  logic v1, r2, v2, r3, v3, r4;
  s1_t  d1;
  s2_t  d2;
  s3_t  d3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fat_kind          <= KIND_FAT12;
      cfg_r.partition_base    <= 32'd0;
      cfg_r.sector_size_shift <= 4'd9;
      cfg_r.cluster_sectors   <= 8'd1;
      cfg_r.reserved_count    <= 16'd1;
      cfg_r.table_copies      <= 8'd2;
      cfg_r.table_sectors     <= 32'd1;
      cfg_r.root_entries      <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAT_KIND:       cfg_r.fat_kind          <= cfg_wdata[1:0];
        CFG_PARTITION_BASE: cfg_r.partition_base    <= cfg_wdata;
        CFG_SECTOR_SHIFT:   cfg_r.sector_size_shift <= cfg_wdata[3:0];
        CFG_CLUSTER_SECS:   cfg_r.cluster_sectors   <= cfg_wdata[7:0];
        CFG_RESERVED_COUNT: cfg_r.reserved_count    <= cfg_wdata[15:0];
        CFG_TABLE_COPIES:   cfg_r.table_copies      <= cfg_wdata[7:0];
        CFG_TABLE_SECTORS:  cfg_r.table_sectors     <= cfg_wdata;
        CFG_ROOT_ENTRIES:   cfg_r.root_entries      <= cfg_wdata[15:0];
        default:            cfg_r                   <= cfg_r;
      endcase
    end
  end

  fca_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_data),
    .dn_valid (v1),
    .dn_ready (r2),
    .dn_item  (d1)
  );

  fca_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (v1),
    .up_ready (r2),
    .up_item  (d1),
    .dn_valid (v2),
    .dn_ready (r3),
    .dn_item  (d2)
  );

  fca_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v2),
    .up_ready (r3),
    .up_item  (d2),
    .dn_valid (v3),
    .dn_ready (r4),
    .dn_item  (d3)
  );

  fca_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (v3),
    .up_ready (r4),
    .up_item  (d3),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_item  (out_data)
  );

`ifndef SYNTHESIS
  // Backpressure reaches the input only with every stage full
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1 && v2 && v3 && out_valid && !out_ready))
    else $error("in_ready low with a stage empty");

  // A continuing chain always decodes below the widest end-of-chain mark
  a_cont_below_eoc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.chain_continues) |-> (out_data.next_cluster < FAT32_EOC))
    else $error("chain_continues set on an end-of-chain value");

  // Address results and decode results never mix in one item
  a_result_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.byte_address != 32'd0)
      |-> (out_data.next_cluster == 32'd0 && !out_data.chain_continues))
    else $error("address and decode fields both set");
`endif

endmodule

FILE: sim/tb.sv
// Testbench for fat_cluster_address_unit: directed table, random geometries, scoreboard.
`timescale 1ns / 1ps

module tb;
  import fca_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int GEOMETRIES  = 14;
  localparam int LOOKUPS_PER = 125;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] kind;
    in_item_t   item;
    logic       known;
    out_item_t  want;
  } probe_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Volume geometry as the block should hold it; starts at the reset values
  cfg_t vol = '{KIND_FAT12, 32'd0, 4'd9, 8'd1, 16'd1, 8'd2, 32'd1, 16'd512};

  out_item_t pending_results[$];
  out_item_t oldest;
  int errors = 0;
  int results_checked = 0;
  int act_seen[4] = '{0, 0, 0, 0};
  int tx_idle_pct = 20;
  int rx_idle_pct = 8;
  int quiet_cycles = 0;

  probe_t probes[25] = '{
    '{KIND_FAT12, '{ACT_LOCATE, 32'd0, 32'd0}, 1'b1, '{32'd512, 32'd0, 1'b0}},
    '{KIND_FAT12, '{ACT_LOCATE, 32'd3, 32'd0}, 1'b1, '{32'd516, 32'd0, 1'b0}},
    '{KIND_FAT12, '{ACT_LOCATE, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
    '{KIND_FAT12, '{ACT_DECODE, 32'd2, 32'h0000_1234}, 1'b1, '{32'd0, 32'h234, 1'b1}},
    '{KIND_FAT12, '{ACT_DECODE, 32'd3, 32'h0000_ABCD}, 1'b1, '{32'd0, 32'hABC, 1'b1}},
    '{KIND_FAT12, '{ACT_DECODE, 32'd4, 32'h0000_0FF8}, 1'b1, '{32'd0, 32'hFF8, 1'b0}},
    '{KIND_FAT12, '{ACT_DECODE, 32'd4, 32'hFFFF_0FF7}, 1'b1, '{32'd0, 32'hFF7, 1'b1}},
    '{KIND_FAT12, '{ACT_DECODE, 32'd5, 32'h0000_FF70}, 1'b1, '{32'd0, 32'hFF7, 1'b1}},
    '{KIND_FAT12, '{ACT_DECODE, 32'd7, 32'h0000_FFFF}, 1'b1, '{32'd0, 32'hFFF, 1'b0}},
    '{KIND_FAT12, '{ACT_DATA, 32'd2, 32'd0}, 1'b1, '{32'd17920, 32'd0, 1'b0}},
    '{KIND_FAT12, '{ACT_DATA, 32'd0, 32'd0}, 1'b1, '{32'd16896, 32'd0, 1'b0}},
    '{KIND_FAT12, '{ACT_DATA, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
    '{KIND_FAT12, '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0},
    '{KIND_FAT16, '{ACT_LOCATE, 32'd8, 32'd0}, 1'b1, '{32'd528, 32'd0, 1'b0}},
    '{KIND_FAT16, '{ACT_DECODE, 32'd1, 32'hFFFF_FFF7}, 1'b1, '{32'd0, 32'hFFF7, 1'b1}},
    '{KIND_FAT16, '{ACT_DECODE, 32'd1, 32'h0000_FFF8}, 1'b1, '{32'd0, 32'hFFF8, 1'b0}},
    '{KIND_FAT16, '{ACT_LOCATE, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
    '{KIND_FAT32, '{ACT_LOCATE, 32'd5, 32'd0}, 1'b1, '{32'd532, 32'd0, 1'b0}},
    '{KIND_FAT32, '{ACT_DECODE, 32'd0, 32'hFFFF_FFF7}, 1'b1, '{32'd0, 32'h0FFF_FFF7, 1'b1}},
    '{KIND_FAT32, '{ACT_DECODE, 32'd0, 32'h0FFF_FFF8}, 1'b1, '{32'd0, 32'h0FFF_FFF8, 1'b0}},
    '{KIND_FAT32, '{ACT_DECODE, 32'd9, 32'hF000_0000}, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{KIND_FAT32, '{ACT_DATA, 32'd2, 32'd0}, 1'b1, '{32'd17920, 32'd0, 1'b0}},
    '{KIND_UNUSED, '{ACT_LOCATE, 32'd100, 32'd0}, 1'b1, '{32'd512, 32'd0, 1'b0}},
    '{KIND_UNUSED, '{ACT_DECODE, 32'd1, 32'hFFFF_FFFF}, 1'b1, '0},
    '{KIND_UNUSED, '{ACT_DATA, 32'd3, 32'd0}, 1'b0, '0}
  };

  fat_cluster_address_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic out_item_t fat_lookup(input cfg_t g, input in_item_t it);
    logic [31:0] offset;
    logic [31:0] bps;
    logic [31:0] root_secs;
    logic [31:0] sector;
    logic [15:0] v16;
    out_item_t   r;
    r = '0;
    v16 = it.raw_entry[15:0];
    case (it.action)
      ACT_LOCATE: begin
        case (g.fat_kind)
          KIND_FAT12: offset = it.cluster + (it.cluster >> 1);
          KIND_FAT16: offset = it.cluster << 1;
          KIND_FAT32: offset = it.cluster << 2;
          default:    offset = 32'd0;
        endcase
        r.byte_address = g.partition_base + (32'(g.reserved_count) << g.sector_size_shift)
                       + offset;
      end
      ACT_DECODE: begin
        case (g.fat_kind)
          KIND_FAT12: begin
            r.next_cluster = it.cluster[0] ? 32'(v16 >> 4) : 32'(v16 & 16'h0FFF);
            r.chain_continues = r.next_cluster < 32'h0000_0FF8;
          end
          KIND_FAT16: begin
            r.next_cluster = 32'(v16);
            r.chain_continues = r.next_cluster < 32'h0000_FFF8;
          end
          KIND_FAT32: begin
            r.next_cluster = it.raw_entry & 32'h0FFF_FFFF;
            r.chain_continues = r.next_cluster < 32'h0FFF_FFF8;
          end
          default: ;
        endcase
      end
      ACT_DATA: begin
        bps = 32'd1 << g.sector_size_shift;
        root_secs = ((32'(g.root_entries) << 5) + bps - 32'd1) >> g.sector_size_shift;
        sector = (it.cluster - 32'd2) * 32'(g.cluster_sectors) + 32'(g.reserved_count)
               + 32'(g.table_copies) * g.table_sectors + root_secs;
        r.byte_address = g.partition_base + (sector << g.sector_size_shift);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly random, with the floor and ceiling of the field now and then
  function automatic logic [31:0] skewed_value(input logic [31:0] all_ones);
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return all_ones;
      default: return $urandom & all_ones;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Drain the pipeline, then load a whole geometry
  task automatic switch_volume(input cfg_t g);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(CFG_FAT_KIND,       32'(g.fat_kind));
    write_reg(CFG_PARTITION_BASE, g.partition_base);
    write_reg(CFG_SECTOR_SHIFT,   32'(g.sector_size_shift));
    write_reg(CFG_CLUSTER_SECS,   32'(g.cluster_sectors));
    write_reg(CFG_RESERVED_COUNT, 32'(g.reserved_count));
    write_reg(CFG_TABLE_COPIES,   32'(g.table_copies));
    write_reg(CFG_TABLE_SECTORS,  g.table_sectors);
    write_reg(CFG_ROOT_ENTRIES,   32'(g.root_entries));
    cfg_we <= 1'b0;
    vol = g;
  endtask

  task automatic send_item(input in_item_t it, input logic known, input out_item_t typed);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(known ? typed : fat_lookup(vol, it));
    act_seen[it.action]++;
  endtask

  // Result side: random stall bursts
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.byte_address !== oldest.byte_address) begin
          $error("byte_address: expected %h, got %h", oldest.byte_address,
                 out_data.byte_address);
          errors++;
        end
        if (out_data.next_cluster !== oldest.next_cluster) begin
          $error("next_cluster: expected %h, got %h", oldest.next_cluster,
                 out_data.next_cluster);
          errors++;
        end
        if (out_data.chain_continues !== oldest.chain_continues) begin
          $error("chain_continues: expected %b, got %b", oldest.chain_continues,
                 out_data.chain_continues);
          errors++;
        end
        results_checked++;
      end
    end
  end

  // Stop a hung run: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("fat_cluster_address_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t     g;
    in_item_t it;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FAT_KIND;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) begin
      if (probes[i].kind != vol.fat_kind) begin
        g = vol;
        g.fat_kind = probes[i].kind;
        switch_volume(g);
      end
      send_item(probes[i].item, probes[i].known, probes[i].want);
    end

    for (int p = 0; p < GEOMETRIES; p++) begin
      if (p == 0) begin
        g = '0;
      end else if (p == 1) begin
        g = '1;
      end else begin
        case (p % 4)
          0:       g.fat_kind = KIND_FAT12;
          1:       g.fat_kind = KIND_FAT16;
          2:       g.fat_kind = KIND_FAT32;
          default: g.fat_kind = KIND_UNUSED;
        endcase
        g.partition_base    = skewed_value(32'hFFFF_FFFF);
        g.sector_size_shift = 4'(skewed_value(32'hF));
        g.cluster_sectors   = 8'(skewed_value(32'hFF));
        g.reserved_count    = 16'(skewed_value(32'hFFFF));
        g.table_copies      = 8'(skewed_value(32'hFF));
        g.table_sectors     = skewed_value(32'hFFFF_FFFF);
        g.root_entries      = 16'(skewed_value(32'hFFFF));
      end
      switch_volume(g);

      // No idling in the last stretch, nor in one geometry out of five
      if (p >= GEOMETRIES - 2 || p % 5 == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(5, 40);
        rx_idle_pct = $urandom_range(2, 12);
      end

      for (int n = 0; n < LOOKUPS_PER; n++) begin
        case ($urandom_range(0, 15))
          0:             it.action = ACT_UNUSED;
          1, 2, 3, 4, 5: it.action = ACT_LOCATE;
          6, 7, 8, 9, 10: it.action = ACT_DECODE;
          default:       it.action = ACT_DATA;
        endcase
        case ($urandom_range(0, 3))
          0:       it.cluster = $urandom_range(0, 15);
          1:       it.cluster = $urandom_range(0, 65535);
          2:       it.cluster = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: it.cluster = $urandom;
        endcase
        // Push the table word near each format's end-of-chain mark
        it.raw_entry = $urandom;
        case ($urandom_range(0, 3))
          0:       it.raw_entry[15:0] = 16'hFFF0 | 16'($urandom_range(0, 15));
          1:       it.raw_entry[11:0] = 12'hFF0 | 12'($urandom_range(0, 15));
          2:       it.raw_entry[27:0] = 28'hFFF_FFF0 | 28'($urandom_range(0, 15));
          default: ;
        endcase
        send_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d locate, %0d decode, %0d data, %0d undefined action",
             results_checked, act_seen[ACT_LOCATE], act_seen[ACT_DECODE],
             act_seen[ACT_DATA], act_seen[ACT_UNUSED]);
    $display("Covered all table kinds plus the spare code over %0d random volume layouts",
             GEOMETRIES);
    if (errors == 0) begin
      $display("fat_cluster_address_unit test passed");
    end else begin
      $display("fat_cluster_address_unit test failed");
    end
    $finish;
  end

endmodule
